@@ rtl/core/mfbp_pkg.sv @@
// Types, codes and pen logic shared by the frame buffer plotter.
`timescale 1ns / 1ps
package mfbp_pkg;

  localparam int BYTE_W      = 8;
  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = 10;
  localparam int FILL_CNT_W  = ADDR_W + 1;

  localparam logic [1:0] KIND_PLOT = 2'd0;
  localparam logic [1:0] KIND_FILL = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [1:0] PEN_ERASE  = 2'd0;
  localparam logic [1:0] PEN_SET    = 2'd1;
  localparam logic [1:0] PEN_INVERT = 2'd2;

  localparam logic [BYTE_W-1:0] MASK_ALL = 8'hff;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [7:0] pixel_x;
    logic signed [7:0] pixel_y;
    logic [1:0]        pen_mode;
    logic [6:0]        read_column;
    logic [2:0]        read_page;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       ignored;
  } res_t;

  function automatic logic [BYTE_W-1:0] apply_pen(input logic [BYTE_W-1:0] old,
                                                  input logic [BYTE_W-1:0] mask,
                                                  input logic [1:0]        pen);
    logic [BYTE_W-1:0] val;
    case (pen)
      PEN_ERASE:  val = old & ~mask;
      PEN_SET:    val = old | mask;
      PEN_INVERT: val = old ^ mask;
      default:    val = old;
    endcase
    return val;
  endfunction

endpackage

@@ rtl/core/mfbp_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module mfbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/monochrome_frame_buffer_plotter.sv @@
// Page-organized monochrome frame buffer: pixel plot, whole-buffer fill, byte read.
//
//   channel  dir  handshake            payload
//   cmd      in   cmd_valid/cmd_ready  mfbp_pkg::cmd_t (kind, x, y, pen, column, page)
//   res      out  res_valid/res_ready  mfbp_pkg::res_t (read_byte, ignored)
//
// Plot and read fetch the byte from the store RAM in ST_IDLE, then in ST_EXEC
// modify, write back and load the result register. Fill walks all 1024 bytes
// with a pipelined read/write pass over the single RAM.
// After reset the same pass clears the store, with cmd_ready low until it ends.
// A full result register stalls ST_EXEC; the RAM read data holds.
`timescale 1ns / 1ps
module monochrome_frame_buffer_plotter #(
  parameter int SCREEN_COLUMNS = 128,
  parameter int SCREEN_ROWS    = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  mfbp_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output mfbp_pkg::res_t res
);
  import mfbp_pkg::*;

  localparam logic [7:0] COL_LIMIT = 8'(SCREEN_COLUMNS);
  localparam logic [7:0] ROW_LIMIT = 8'(SCREEN_ROWS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_FILL = 3'b100
  } state_t;

  state_t state;

  logic [1:0]            op_kind;
  logic [1:0]            op_pen;
  logic                  op_ign;
  logic [BYTE_W-1:0]     op_mask;
  logic [ADDR_W-1:0]     op_addr;
  logic                  clr_pass;
  logic [FILL_CNT_W-1:0] fill_cnt;
  logic                  wr_pend;
  logic [ADDR_W-1:0]     wr_addr;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [BYTE_W-1:0]     ram_wdata;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [BYTE_W-1:0]     ram_rdata;

  logic                  cmd_fire;
  logic                  slot_free;
  logic                  on_screen;
  logic [ADDR_W-1:0]     cmd_addr;
  logic                  fill_done;

  assign cmd_ready = (state == ST_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign slot_free = !res_valid || res_ready;
  assign fill_done = fill_cnt[ADDR_W] && !wr_pend;

  assign on_screen = !cmd.pixel_x[7] && (unsigned'(cmd.pixel_x) < COL_LIMIT) &&
                     !cmd.pixel_y[7] && (unsigned'(cmd.pixel_y) < ROW_LIMIT);

  always_comb begin
    if (cmd.kind == KIND_PLOT) begin
      cmd_addr = {cmd.pixel_x[6:0], cmd.pixel_y[5:3]};
    end else begin
      cmd_addr = {cmd.read_column, cmd.read_page};
    end
  end

  // RAM port control: idle reads the addressed byte, exec writes a plot back, fill streams through the store
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = cmd_addr;
    ram_we    = 1'b0;
    ram_waddr = op_addr;
    ram_wdata = apply_pen(ram_rdata, op_mask, op_pen);
    unique case (state)
      ST_IDLE: begin
        ram_re = cmd_valid;
      end
      ST_EXEC: begin
        ram_we = slot_free && (op_kind == KIND_PLOT) && !op_ign;
      end
      ST_FILL: begin
        ram_re    = !fill_cnt[ADDR_W];
        ram_raddr = fill_cnt[ADDR_W-1:0];
        ram_we    = wr_pend;
        ram_waddr = wr_addr;
        ram_wdata = apply_pen(ram_rdata, MASK_ALL, op_pen);
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      clr_pass  <= 1'b1;
      fill_cnt  <= '0;
      wr_pend   <= 1'b0;
      op_pen    <= PEN_ERASE;
      res_valid <= 1'b0;
    end else begin
      // drop the beat once taken, unless the write-back cycle loads the next one
      if (res_valid && res_ready && (state != ST_EXEC)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_fire) begin
            op_kind  <= cmd.kind;
            op_pen   <= cmd.pen_mode;
            op_ign   <= (cmd.kind == KIND_PLOT) && !on_screen;
            op_mask  <= BYTE_W'(1) << cmd.pixel_y[2:0];
            op_addr  <= cmd_addr;
            fill_cnt <= '0;
            wr_pend  <= 1'b0;
            state    <= (cmd.kind == KIND_FILL) ? ST_FILL : ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (slot_free) begin
            res_valid     <= 1'b1;
            res.read_byte <= (op_kind == KIND_READ) ? ram_rdata : '0;
            res.ignored   <= op_ign;
            state         <= ST_IDLE;
          end
        end
        ST_FILL: begin
          // write stage trails the read stage by one address
          wr_pend <= !fill_cnt[ADDR_W];
          wr_addr <= fill_cnt[ADDR_W-1:0];
          if (!fill_cnt[ADDR_W]) begin
            fill_cnt <= fill_cnt + 1'b1;
          end
          if (fill_done) begin
            clr_pass <= 1'b0;
            state    <= clr_pass ? ST_IDLE : ST_EXEC;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  mfbp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_no_write_idle : assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ram_we)
    else $error("store written while idle");

  a_fill_order : assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL && wr_pend) |-> (ADDR_W'(wr_addr + 1'b1) == fill_cnt[ADDR_W-1:0]))
    else $error("fill write stage out of step with read stage");

  a_short_op : assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && cmd.kind != KIND_FILL) |=> (state == ST_EXEC))
    else $error("plot or read did not reach the write-back cycle");

  a_no_read_in_exec : assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> !ram_re)
    else $error("read data overwritten before write-back");

endmodule
